### src/lph_pkg.sv
// Package: constants, codes and types shared by the linear probing hash table files.
package lph_pkg;

  localparam int unsigned TableSize = 32;
  localparam int unsigned SlotW     = $clog2(TableSize);
  localparam int unsigned KeyW      = 31;
  localparam int unsigned SlotOutW  = 5;

  typedef logic [KeyW-1:0]     key_t;
  typedef logic [SlotW-1:0]    pos_t;
  typedef logic [SlotOutW-1:0] slot_t;

  typedef enum logic {
    ActInsert = 1'b0,
    ActSearch = 1'b1
  } action_e;

  typedef enum logic [2:0] {
    StatInserted = 3'd0,
    StatFound    = 3'd1,
    StatNotFound = 3'd2,
    StatFull     = 3'd3,
    StatZeroKey  = 3'd4
  } status_e;

endpackage

### src/lph_if.sv
// Interfaces: request and response channels of the linear probing hash table.
interface lph_req_if;
  import lph_pkg::*;

  logic    valid;
  logic    ready;
  action_e action;
  key_t    key;

  modport source (output valid, output action, output key, input ready);
  modport sink   (input valid, input action, input key, output ready);
endinterface

interface lph_rsp_if;
  import lph_pkg::*;

  logic    valid;
  logic    ready;
  status_e status;
  slot_t   slot;

  modport source (output valid, output status, output slot, input ready);
  modport sink   (input valid, input status, input slot, output ready);
endinterface

### src/linear_probe_hash_table.sv
// Top level: linear probing hash table with a one-port key memory.
//
// Usage:
//   req_i carries one request: action (insert or search) and a 31-bit key.
//   rsp_o returns one response per request: status and slot.
//   A request is taken when valid and ready are both high at a rising edge.
//   Requests are handled one at a time. The block reads the home slot
//   (key modulo the table size) at the accepting edge and then checks one
//   slot per cycle until the request ends, probing 1 to TableSize slots.
//   Each probe is a registered read of the key memory. A zero key is
//   answered at the first check, without probing further. The request
//   port reopens in the cycle after the response is registered.
//   The response sits in an output register; a new request is taken while
//   it waits. If the receiver stalls, the finished request holds in the
//   check state until the output register is free.
//   Reset clears the control state and the per-slot valid bits, so every
//   slot reads as empty at once; no clearing pass is needed.
module linear_probe_hash_table (
  input  logic clk_i,
  input  logic rst_ni,
  lph_req_if.sink   req_i,
  lph_rsp_if.source rsp_o
);
  import lph_pkg::*;

  typedef enum logic [1:0] {
    FsmIdle  = 2'b01,
    FsmCheck = 2'b10
  } fsm_e;

  fsm_e    state_q, state_d;
  action_e act_q;
  key_t    key_q;
  pos_t    pos_q, pos_d;
  pos_t    cnt_q, cnt_d;

  key_t             mem [TableSize];
  logic [TableSize-1:0] vld_q;
  key_t             rdata_q;
  logic             rvld_q;
  pos_t             raddr;

  logic    rsp_valid_q;
  status_e rsp_status_q;
  slot_t   rsp_slot_q;

  key_t    held;
  logic    last, done, wr_en, out_free, accept;
  status_e status_c;
  pos_t    pos_next, home;

  assign home     = pos_t'(req_i.key % TableSize);
  assign accept   = req_i.valid && req_i.ready;
  assign out_free = !rsp_valid_q || rsp_o.ready;
  assign held     = rvld_q ? rdata_q : '0;
  assign last     = (cnt_q == pos_t'(TableSize - 1));
  assign pos_next = (pos_q == pos_t'(TableSize - 1)) ? '0 : pos_q + pos_t'(1);

  assign req_i.ready  = (state_q == FsmIdle);
  assign rsp_o.valid  = rsp_valid_q;
  assign rsp_o.status = rsp_status_q;
  assign rsp_o.slot   = rsp_slot_q;

  always_comb begin
    done     = 1'b0;
    wr_en    = 1'b0;
    status_c = StatNotFound;
    if (key_q == '0) begin
      done     = 1'b1;
      status_c = StatZeroKey;
    end else if (act_q == ActInsert) begin
      if (held == '0) begin
        done     = 1'b1;
        wr_en    = 1'b1;
        status_c = StatInserted;
      end else if (last) begin
        done     = 1'b1;
        status_c = StatFull;
      end
    end else begin
      if (held == key_q) begin
        done     = 1'b1;
        status_c = StatFound;
      end else if (held == '0 || last) begin
        done     = 1'b1;
        status_c = StatNotFound;
      end
    end
  end

  always_comb begin
    state_d = state_q;
    pos_d   = pos_q;
    cnt_d   = cnt_q;
    raddr   = pos_q;
    case (state_q)
      FsmIdle: begin
        raddr = home;
        if (accept) begin
          pos_d   = home;
          cnt_d   = '0;
          state_d = FsmCheck;
        end
      end
      FsmCheck: begin
        if (!done) begin
          pos_d = pos_next;
          cnt_d = cnt_q + pos_t'(1);
          raddr = pos_next;
        end else if (out_free) begin
          state_d = FsmIdle;
        end
      end
      default: begin
        state_d = FsmIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= FsmIdle;
      vld_q       <= '0;
      rsp_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (state_q == FsmCheck && done && out_free) begin
        rsp_valid_q <= 1'b1;
        if (wr_en) begin
          vld_q[pos_q] <= 1'b1;
        end
      end else if (rsp_o.ready) begin
        rsp_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    pos_q <= pos_d;
    cnt_q <= cnt_d;
    if (accept) begin
      act_q <= req_i.action;
      key_q <= req_i.key;
    end
    if (state_q == FsmCheck && done && out_free) begin
      rsp_status_q <= status_c;
      rsp_slot_q   <= (status_c == StatInserted || status_c == StatFound) ?
                      slot_t'(pos_q) : '0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == FsmCheck && done && out_free && wr_en) begin
      mem[pos_q] <= key_q;
    end
    rdata_q <= mem[raddr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rvld_q <= 1'b0;
    end else begin
      rvld_q <= vld_q[raddr];
    end
  end

endmodule

### sim/linear_probe_hash_table_test.sv
// Testbench: linear probing hash table checked against a predictor, random handshake gaps.
`timescale 1ns / 1ps

module linear_probe_hash_table_test;
  import lph_pkg::*;

  typedef struct packed {
    status_e status;
    slot_t   slot;
  } outcome_t;

  logic clk_i;
  logic rst_ni;

  lph_req_if req_if ();
  lph_rsp_if rsp_if ();

  linear_probe_hash_table dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_if),
    .rsp_o  (rsp_if)
  );

  key_t        slot_keys [TableSize];
  int unsigned filled_slots;
  key_t        stored_keys [$];
  outcome_t    pending_outcomes [$];
  int unsigned fail_count;
  bit          no_idle;

  initial begin
    clk_i = 1'b0;
  end

  always #5 clk_i = ~clk_i;

  function automatic outcome_t probe_table(action_e act, key_t k);
    outcome_t    res;
    int unsigned pos;
    res.slot = '0;
    if (k == '0) begin
      res.status = StatZeroKey;
      return res;
    end
    pos = k % TableSize;
    for (int unsigned n = 0; n < TableSize; n++) begin
      if (act == ActInsert) begin
        if (slot_keys[pos] == '0) begin
          slot_keys[pos] = k;
          filled_slots++;
          stored_keys = {stored_keys, k};
          res.status = StatInserted;
          res.slot   = slot_t'(pos);
          return res;
        end
      end else begin
        if (slot_keys[pos] == k) begin
          res.status = StatFound;
          res.slot   = slot_t'(pos);
          return res;
        end
        if (slot_keys[pos] == '0) begin
          res.status = StatNotFound;
          return res;
        end
      end
      pos = (pos + 1) % TableSize;
    end
    res.status = (act == ActInsert) ? StatFull : StatNotFound;
    return res;
  endfunction

  task automatic send_request(action_e act, key_t k);
    int unsigned gap;
    outcome_t    predicted;
    gap = no_idle ? 0 : $urandom_range(0, 10);
    if (gap > 0) begin
      req_if.valid = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    req_if.valid  = 1'b1;
    req_if.action = act;
    req_if.key    = k;
    do @(posedge clk_i); while (!req_if.ready);
    predicted = probe_table(act, k);
    pending_outcomes = {pending_outcomes, predicted};
    @(negedge clk_i);
  endtask

  task automatic drain_outcomes();
    req_if.valid = 1'b0;
    while (pending_outcomes.size() != 0) @(negedge clk_i);
  endtask

  function automatic key_t pick_key();
    int unsigned sel;
    sel = $urandom_range(0, 99);
    if (sel < 60) begin
      return key_t'($urandom_range(0, 31) + 32 * $urandom_range(0, 7));
    end else if (sel < 85 && stored_keys.size() != 0) begin
      return stored_keys[$urandom_range(0, stored_keys.size() - 1)];
    end
    return key_t'($urandom);
  endfunction

  // receiver: hold ready low for a random stall before each response, with no stall while no_idle is set
  initial begin
    int unsigned stall;
    rsp_if.ready = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      stall = no_idle ? 0 : $urandom_range(0, 10);
      if (stall > 0) begin
        rsp_if.ready = 1'b0;
        repeat (stall) @(negedge clk_i);
      end
      rsp_if.ready = 1'b1;
      do @(posedge clk_i); while (!rsp_if.valid);
    end
  end

  always @(posedge clk_i) begin
    outcome_t want;
    if (rst_ni && rsp_if.valid && rsp_if.ready) begin
      if (pending_outcomes.size() == 0) begin
        $error("unexpected response: status %0d slot %0d", rsp_if.status, rsp_if.slot);
        fail_count++;
      end else begin
        want = pending_outcomes.pop_front();
        if (rsp_if.status !== want.status) begin
          $error("status: expected %0d, actual %0d", want.status, rsp_if.status);
          fail_count++;
        end
        if (rsp_if.slot !== want.slot) begin
          $error("slot: expected %0d, actual %0d", want.slot, rsp_if.slot);
          fail_count++;
        end
      end
    end
  end

  task automatic test_zero_key();
    send_request(ActInsert, '0);
    send_request(ActSearch, '0);
  endtask

  task automatic test_probe_chain();
    send_request(ActSearch, key_t'(5));
    send_request(ActInsert, key_t'(31'h7FFF_FFFF));
    send_request(ActSearch, key_t'(31'h7FFF_FFFF));
    send_request(ActInsert, key_t'(1));
    send_request(ActSearch, key_t'(1));
    send_request(ActSearch, key_t'(33));
    send_request(ActInsert, key_t'(33));
    send_request(ActInsert, key_t'(33));
    send_request(ActSearch, key_t'(33));
    send_request(ActInsert, key_t'(63));
    send_request(ActSearch, key_t'(63));
    send_request(ActSearch, key_t'(95));
    send_request(ActSearch, key_t'(31'h4000_0000));
    send_request(ActInsert, key_t'(31'h5555_5555));
    send_request(ActSearch, key_t'(31'h2AAA_AAAA));
    drain_outcomes();
  endtask

  task automatic test_random_mix();
    action_e act;
    for (int i = 0; i < 1300; i++) begin
      if (i % 100 == 0) begin
        no_idle = ($urandom_range(0, 3) == 0);
      end
      if (i == 650) begin
        drain_outcomes();
      end
      act = ($urandom_range(0, 15) == 0) ? ActInsert : ActSearch;
      send_request(act, pick_key());
    end
    no_idle = 1'b0;
  endtask

  task automatic test_full_table();
    while (filled_slots < TableSize) begin
      send_request(ActInsert, key_t'($urandom_range(1, 31) + 32 * $urandom_range(0, 7)));
    end
    send_request(ActInsert, key_t'(5));
    send_request(ActInsert, key_t'(31'h7FFF_FFFF));
    send_request(ActSearch, key_t'(31'h1234_5678));
    send_request(ActSearch, stored_keys[$]);
    send_request(ActSearch, '0);
  endtask

  initial begin
    rst_ni        = 1'b0;
    req_if.valid  = 1'b0;
    req_if.action = ActInsert;
    req_if.key    = '0;
    fail_count    = 0;
    filled_slots  = 0;
    no_idle       = 1'b0;
    for (int i = 0; i < TableSize; i++) slot_keys[i] = '0;
    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);
    test_zero_key();
    test_probe_chain();
    test_random_mix();
    test_full_table();
    drain_outcomes();
    repeat (40) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("linear_probe_hash_table: match");
    end else begin
      $display("linear_probe_hash_table: mismatch");
    end
    $finish;
  end

  initial begin
    #5ms;
    $display("linear_probe_hash_table: mismatch");
    $finish;
  end

endmodule

### files.f
src/lph_pkg.sv
src/lph_if.sv
src/linear_probe_hash_table.sv
sim/linear_probe_hash_table_test.sv
